### hdl/sync_word_packet_deframer_crc32_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync word packet deframer.
// Each macro expects signals named clk and rst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef SYNC_WORD_PACKET_DEFRAMER_CRC32_DEFINES_SVH
`define SYNC_WORD_PACKET_DEFRAMER_CRC32_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SWPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swpd assertion failed");

// Next-cycle implication.
`define SWPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swpd assertion failed");

`else

`define SWPD_ASSERT_IMP(lbl, ante, cons)
`define SWPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hdl/swpd_pkg.sv
// ---------------------------------------------------------------------------
// swpd_pkg
// Shared types and constants for the sync word packet deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package swpd_pkg;

  localparam logic [31:0] SYNC_WORD_RST = 32'hFEED_F00D;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  // Command words, ASCII little-endian.
  localparam logic [31:0] CMD_SYNC = 32'h434E_5953;
  localparam logic [31:0] CMD_PING = 32'h474E_4950;
  localparam logic [31:0] CMD_READ = 32'h4441_4552;
  localparam logic [31:0] CMD_WRIT = 32'h5449_5257;

  typedef enum logic [2:0] {
    CLS_SYNC    = 3'd0,
    CLS_PING    = 3'd1,
    CLS_READ    = 3'd2,
    CLS_WRITE   = 3'd3,
    CLS_UNKNOWN = 3'd4
  } cmd_class_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Header words: [0] id, [1] command, [2] length, [3] crc.
  typedef logic [3:0][31:0] hdr_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    hdr_t       hdr;
    logic       crc_ok;
    cmd_class_t cls;
    logic       last;
  } swpd_result_t;

  // Results produced by one accepted byte (0, 1 or 2).
  typedef struct packed {
    logic [1:0]   n;
    swpd_result_t r0;
    swpd_result_t r1;
  } swpd_push_t;

endpackage

`default_nettype wire

### hdl/swpd_core.sv
// ---------------------------------------------------------------------------
// swpd_core
// Deframer state: sync hunt, header capture, payload CRC, result forming.
// ---------------------------------------------------------------------------
`default_nettype none

module swpd_core import swpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  output swpd_push_t       push
);

  phase_t      phase_r,  phase_nxt;
  logic [31:0] sync_r;
  logic [31:0] win_r,    win_nxt;
  hdr_t        hw_r,     hw_nxt;
  logic [4:0]  hc_r,     hc_nxt;
  logic [31:0] pc_r,     pc_nxt;
  logic [31:0] crc_r,    crc_nxt;

  logic [31:0] crc_upd;
  logic [31:0] pc_inc;
  logic [31:0] win_sh;
  logic [4:0]  hc_inc;
  hdr_t        hw_hdr;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
    end
    return x;
  endfunction

  function automatic cmd_class_t class_of(input logic [31:0] cmd);
    cmd_class_t c;
    if (cmd == CMD_SYNC)      c = CLS_SYNC;
    else if (cmd == CMD_PING) c = CLS_PING;
    else if (cmd == CMD_READ) c = CLS_READ;
    else if (cmd == CMD_WRIT) c = CLS_WRITE;
    else                      c = CLS_UNKNOWN;
    return c;
  endfunction

  function automatic swpd_result_t mk_res(input logic kind, input logic [7:0] d,
                                          input logic ok, input logic lst,
                                          input hdr_t h);
    swpd_result_t r;
    r.kind      = kind;
    r.data_byte = d;
    r.hdr       = h;
    r.crc_ok    = ok;
    r.cls       = class_of(h[1]);
    r.last      = lst;
    return r;
  endfunction

  assign crc_upd = crc_byte(crc_r, rx_byte);
  assign pc_inc  = pc_r + 32'd1;
  assign win_sh  = {rx_byte, win_r[31:8]};
  assign hc_inc  = hc_r + 5'd1;

  always_comb begin
    hw_hdr = hw_r;
    hw_hdr[hc_r[3:2]] = hw_r[hc_r[3:2]] | ({24'd0, rx_byte} << {hc_r[1:0], 3'b000});
  end

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    hw_nxt    = hw_r;
    hc_nxt    = hc_r;
    pc_nxt    = pc_r;
    crc_nxt   = crc_r;
    push      = '0;
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          hw_nxt = hw_hdr;
          hc_nxt = hc_inc;
          if (hc_inc[4]) begin
            if (hw_hdr[2] == 32'd0) begin
              push.n    = 2'd1;
              push.r0   = mk_res(KIND_END, 8'd0, (~crc_r == hw_hdr[3]), 1'b1, hw_hdr);
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          pc_nxt  = pc_inc;
          push.r0 = mk_res(KIND_BYTE, rx_byte, 1'b0, (pc_inc != hw_r[2]), hw_r);
          if (pc_inc == hw_r[2]) begin
            push.n    = 2'd2;
            push.r1   = mk_res(KIND_END, 8'd0, (~crc_upd == hw_r[3]), 1'b1, hw_r);
            phase_nxt = PH_HUNT;
          end else begin
            push.n = 2'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          win_nxt   = win_sh;
          if (win_sh == sync_r) begin
            win_nxt   = '0;
            hw_nxt    = '0;
            hc_nxt    = '0;
            pc_nxt    = '0;
            crc_nxt   = '1;
            phase_nxt = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sync_r  <= SYNC_WORD_RST;
      win_r   <= '0;
      hw_r    <= '0;
      hc_r    <= '0;
      pc_r    <= '0;
      crc_r   <= '1;
    end else begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      hw_r    <= hw_nxt;
      hc_r    <= hc_nxt;
      pc_r    <= pc_nxt;
      crc_r   <= crc_nxt;
      if (cfg_we) begin
        sync_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/swpd_fifo.sv
// ---------------------------------------------------------------------------
// swpd_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ---------------------------------------------------------------------------
`default_nettype none

module swpd_fifo import swpd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire swpd_push_t                 push,
  input  wire logic                       pop,
  output swpd_result_t                    head,
  output logic                            not_empty,
  output logic [$clog2(DEPTH+1)-1:0]      cnt
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  swpd_result_t  mem [DEPTH];
  logic [IW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr2;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr2       = inc(wr_r);
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop & not_empty;
  assign head      = mem[rd_r];
  assign cnt       = cnt_r;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = do_pop ? inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.n) - CW'(do_pop);
    case (push.n)
      2'd1:    wr_nxt = wr2;
      2'd2:    wr_nxt = inc(wr2);
      default: wr_nxt = wr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.n != 2'd0 && IW'(i) == wr_r) begin
        mem[i] <= push.r0;
      end
      if (push.n == 2'd2 && IW'(i) == wr2) begin
        mem[i] <= push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sync_word_packet_deframer_crc32.sv
// ---------------------------------------------------------------------------
// sync_word_packet_deframer_crc32
// Byte stream deframer: sync word hunt, 16-byte header, streamed payload
// with CRC-32 check, packet-end report with command class.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid / in_stall     | in_rx_byte
//  out     | out_valid / out_stall   | out_kind .. out_last (nine fields)
//  cfg     | cfg_valid / cfg_ready   | cfg_sync_word
//
//  The framer state updates in the cycle a byte is accepted and its
//  results land in the result queue the same edge.
//  Sustained rate is one byte per cycle while the output side keeps up.
//  in_stall rises when the queue has fewer than two free slots, since one
//  byte may produce two results (last payload byte plus packet end).
//  Synchronous reset: hunt phase, sync word 0xFEEDF00D, queue empty.
//  cfg_ready is always high; write the sync word only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_word_packet_deframer_crc32_defines.svh"

module sync_word_packet_deframer_crc32 import swpd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte transaction
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  // result transaction
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_data_byte,
  output logic [31:0]      out_packet_id,
  output logic [31:0]      out_command_word,
  output logic [31:0]      out_length_field,
  output logic [31:0]      out_received_crc,
  output logic             out_crc_ok,
  output logic [2:0]       out_command_class,
  output logic             out_last,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_sync_word
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic          in_acc;
  logic          out_acc;
  swpd_push_t    push;
  swpd_result_t  head;
  logic [CW-1:0] q_cnt;

  // Hold off input unless two result slots are free.
  assign in_stall  = (q_cnt > CW'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid & ~out_stall;
  assign cfg_ready = 1'b1;

  swpd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .rx_byte  (in_rx_byte),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_sync_word),
    .push     (push)
  );

  swpd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (~out_stall),
    .head      (head),
    .not_empty (out_valid),
    .cnt       (q_cnt)
  );

  // Result fields straight from the queue head.
  assign out_kind          = head.kind;
  assign out_data_byte     = head.data_byte;
  assign out_packet_id     = head.hdr[0];
  assign out_command_word  = head.hdr[1];
  assign out_length_field  = head.hdr[2];
  assign out_received_crc  = head.hdr[3];
  assign out_crc_ok        = head.crc_ok;
  assign out_command_class = head.cls;
  assign out_last          = head.last;

  // Queue never overfills.
  `SWPD_ASSERT_IMP(a_q_bound, 1'b1, q_cnt <= CW'(FIFO_DEPTH))
  // A double push is always payload byte then packet end.
  `SWPD_ASSERT_IMP(a_pair, push.n == 2'd2, (push.r0.kind == KIND_BYTE) && !push.r0.last && (push.r1.kind == KIND_END) && push.r1.last)
  // Draining with nothing pushed shrinks the queue by one.
  `SWPD_ASSERT_NXT(a_drain, out_acc && (push.n == 2'd0), q_cnt == $past(q_cnt) - 1'b1)

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: sync word packet deframer regression
// Feeds framed byte streams (sync word, 16-byte header, payload) mixed with
// noise and broken frames, predicts every payload byte and packet-end
// transaction in a scoreboard, and checks the result channel field by field
// under random and sustained backpressure on both sides.
// ---------------------------------------------------------------------------
module tb;
  import swpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Predicts the deframer bytewise and holds the results still owed.
  class packet_result_tracker;
    logic [31:0]  sync_word;
    phase_t       phase;
    logic [31:0]  window;
    hdr_t         hdr;
    logic [4:0]   hdr_count;
    logic [31:0]  pay_count;
    logic [31:0]  crc_acc;
    swpd_result_t expected_results[$];
    int unsigned  errors;

    function new();
      sync_word = SYNC_WORD_RST;
      phase     = PH_HUNT;
      window    = '0;
      hdr       = '0;
      hdr_count = '0;
      pay_count = '0;
      crc_acc   = '1;
      errors    = 0;
    endfunction

    // Reflected CRC-32, one byte.
    static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++)
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void queue_result(logic kind, logic [7:0] data, logic ok, logic lst);
      swpd_result_t r;
      r.kind      = kind;
      r.data_byte = data;
      r.hdr       = hdr;
      r.crc_ok    = ok;
      r.last      = lst;
      case (hdr[1])
        CMD_SYNC: r.cls = CLS_SYNC;
        CMD_PING: r.cls = CLS_PING;
        CMD_READ: r.cls = CLS_READ;
        CMD_WRIT: r.cls = CLS_WRITE;
        default:  r.cls = CLS_UNKNOWN;
      endcase
      expected_results.push_back(r);
    endfunction

    function void accept_rx_byte(logic [7:0] b);
      case (phase)
        PH_HEADER: begin
          hdr[hdr_count[3:2]][8*hdr_count[1:0] +: 8] = b;
          hdr_count = hdr_count + 5'd1;
          if (hdr_count >= 5'd16) begin
            // zero length: packet end straight after the header
            if (hdr[2] == 32'h0) begin
              queue_result(KIND_END, 8'h00, (~crc_acc) == hdr[3], 1'b1);
              phase = PH_HUNT;
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_acc   = crc32_step(crc_acc, b);
          pay_count = pay_count + 32'd1;
          if (pay_count == hdr[2]) begin
            queue_result(KIND_BYTE, b, 1'b0, 1'b0);
            queue_result(KIND_END, 8'h00, (~crc_acc) == hdr[3], 1'b1);
            phase = PH_HUNT;
          end else begin
            queue_result(KIND_BYTE, b, 1'b0, 1'b1);
          end
        end
        default: begin
          // hunting; the window is only cleared by a match
          phase  = PH_HUNT;
          window = {b, window[31:8]};
          if (window == sync_word) begin
            window    = '0;
            hdr       = '0;
            hdr_count = '0;
            pay_count = '0;
            crc_acc   = '1;
            phase     = PH_HEADER;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(swpd_result_t seen);
      swpd_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d data 0x%0h",
               seen.kind, seen.data_byte);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind",          want.kind,      seen.kind);
      compare_field("data_byte",     want.data_byte, seen.data_byte);
      compare_field("packet_id",     want.hdr[0],    seen.hdr[0]);
      compare_field("command_word",  want.hdr[1],    seen.hdr[1]);
      compare_field("length_field",  want.hdr[2],    seen.hdr[2]);
      compare_field("received_crc",  want.hdr[3],    seen.hdr[3]);
      compare_field("crc_ok",        want.crc_ok,    seen.crc_ok);
      compare_field("command_class", want.cls,       seen.cls);
      compare_field("last",          want.last,      seen.last);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and DUT
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [31:0] out_packet_id;
  logic [31:0] out_command_word;
  logic [31:0] out_length_field;
  logic [31:0] out_received_crc;
  logic        out_crc_ok;
  logic [2:0]  out_command_class;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_sync_word = 32'h0;

  always #4 clk = ~clk;

  sync_word_packet_deframer_crc32 DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_packet_id     (out_packet_id),
    .out_command_word  (out_command_word),
    .out_length_field  (out_length_field),
    .out_received_crc  (out_received_crc),
    .out_crc_ok        (out_crc_ok),
    .out_command_class (out_command_class),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sync_word     (cfg_sync_word)
  );

  packet_result_tracker tracker = new();

  int          snd_idle_pct  = 0;   // sender gap chance per cycle, percent
  int          rcv_stall_pct = 0;   // receiver stall chance per cycle, percent
  int          hold_left     = 0;   // forced receiver hold-off, in cycles
  int unsigned bytes_pushed  = 0;
  int unsigned cycle_count   = 0;

  // -------------------------------------------------------------------------
  // Receiver side: random stall, or a long forced hold-off when requested.
  // The hold-off is counted here so the sender keeps running meanwhile.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Result monitor: payload is assembled combinationally and sampled at the
  // rising edge, so it still holds the pre-edge value.
  swpd_result_t seen_result;
  always_comb begin
    seen_result.kind      = out_kind;
    seen_result.data_byte = out_data_byte;
    seen_result.hdr[0]    = out_packet_id;
    seen_result.hdr[1]    = out_command_word;
    seen_result.hdr[2]    = out_length_field;
    seen_result.hdr[3]    = out_received_crc;
    seen_result.crc_ok    = out_crc_ok;
    seen_result.cls       = cmd_class_t'(out_command_class);
    seen_result.last      = out_last;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(seen_result);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks. All run from a falling edge and return on one.
  // -------------------------------------------------------------------------

  // One byte transaction, with random gaps ahead of it. Valid stays high
  // into the next call when no gap is drawn.
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.accept_rx_byte(b);
    bytes_pushed++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected transaction has come back, then
  // let the last hunted bytes settle, since they give no result to wait on.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sync_word(input logic [31:0] w);
    wait_idle();
    cfg_valid     = 1'b1;
    cfg_sync_word = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.sync_word = w;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full frame: sync word, header (id, command, length, crc), payload.
  // Huge lengths only get a short run of payload bytes.
  task automatic send_packet(input logic [31:0] cmd, input logic [31:0] len,
                             input bit bad_crc);
    logic [7:0]  payload[$];
    logic [31:0] crc;
    hdr_t        words;
    int unsigned n_pay;
    n_pay = (len > 32'd200) ? 40 : len;
    crc   = '1;
    for (int i = 0; i < n_pay; i++) begin
      payload.push_back(8'($urandom_range(255)));
      crc = packet_result_tracker::crc32_step(crc, payload[i]);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(31));
    words[0] = $urandom;
    words[1] = cmd;
    words[2] = len;
    words[3] = crc;
    for (int i = 0; i < 4; i++) send_rx_byte(tracker.sync_word[8*i +: 8]);
    for (int i = 0; i < 16; i++) send_rx_byte(words[i/4][8*(i%4) +: 8]);
    foreach (payload[i]) send_rx_byte(payload[i]);
  endtask

  // Mostly well-formed frames with random content; the rest is noise and
  // frames cut off inside the sync word.
  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int          pick;
    logic [31:0] cmd;
    logic [31:0] len;
    stop_at = bytes_pushed + n_bytes;
    while (bytes_pushed < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        case ($urandom_range(4))
          0:       cmd = CMD_SYNC;
          1:       cmd = CMD_PING;
          2:       cmd = CMD_READ;
          3:       cmd = CMD_WRIT;
          default: cmd = $urandom;
        endcase
        pick = $urandom_range(99);
        if (pick < 20)      len = 0;
        else if (pick < 70) len = $urandom_range(8, 1);
        else if (pick < 95) len = $urandom_range(40, 9);
        else                len = $urandom_range(100, 41);
        send_packet(cmd, len, $urandom_range(9) == 0);
      end else if (pick < 93) begin
        repeat ($urandom_range(6, 1)) send_rx_byte(8'($urandom_range(255)));
      end else begin
        // partial sync word followed by a random byte
        for (int i = 0; i < $urandom_range(3, 1); i++)
          send_rx_byte(tracker.sync_word[8*i +: 8]);
        send_rx_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: byte extremes while hunting, then a zero-length frame whose
    // header CRC is zero (so the CRC check passes with no payload).
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(8'hA5);
    for (int i = 0; i < 4; i++) send_rx_byte(SYNC_WORD_RST[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_rx_byte(8'hFF);    // id
    for (int i = 0; i < 4; i++) send_rx_byte(CMD_SYNC[8*i +: 8]);
    for (int i = 0; i < 8; i++) send_rx_byte(8'h00);    // length, crc

    // Phase 1: sender idles 31 %, receiver stalls 80 %.
    snd_idle_pct  = 31;
    rcv_stall_pct = 80;
    run_traffic(350);
    // Nearly all zero: a window cleared by the last match must not match
    // on the first sync byte of the next frame.
    write_sync_word(32'h0000_0001);
    run_traffic(200);

    // Phase 2: the other way round.
    snd_idle_pct  = 80;
    rcv_stall_pct = 31;
    write_sync_word(32'hFFFF_FFFF);
    run_traffic(250);
    write_sync_word($urandom);
    run_traffic(200);

    // Phase 3: no idling. First a long receiver hold-off while a frame with
    // a long payload keeps coming, so the result queue fills and the block
    // stalls its input; then the sender pauses until everything drained.
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_sync_word(SYNC_WORD_RST);
    in_valid = 1'b0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    send_packet(CMD_WRIT, 48, 1'b0);
    wait_idle();
    run_traffic(450);

    // Huge length: payload streams with no end, nothing is buffered.
    send_packet(CMD_READ, $urandom_range(32'hFFFF_FFFF, 32'h1000_0000), 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
